// ----- design/scfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared constants for the serial command frame parser: command characters,
// update target codes and default sizes.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int FRAME_CAPACITY_DEFAULT = 50;
  localparam int VALUE_BITS_DEFAULT     = 32;

  localparam logic [7:0] CH_DIR_LO    = 8'h41;
  localparam logic [7:0] CH_DIR_HI    = 8'h48;
  localparam logic [7:0] CH_DIR_BASE  = 8'h40;
  localparam logic [7:0] CH_STOP      = 8'h5A;
  localparam logic [7:0] CH_OPEN      = 8'h7B;
  localparam logic [7:0] CH_CLOSE     = 8'h7D;
  localparam logic [7:0] CH_TAG_PID   = 8'h50;
  localparam logic [7:0] CH_TAG_FLASH = 8'h57;
  localparam logic [7:0] CH_ID_SKIP   = 8'h23;
  localparam logic [7:0] CH_ID_VEL    = 8'h30;
  localparam logic [7:0] CH_ID_KP     = 8'h31;
  localparam logic [7:0] CH_ID_KI     = 8'h32;
  localparam logic [7:0] RAW_DIR_LIMIT = 8'd10;
  localparam logic signed [8:0] DIGIT_BASE = 9'sd48;

  localparam int POS_ID  = 1;
  localparam int POS_TAG = 3;

  typedef enum logic [1:0] {
    TARGET_NONE = 2'd0,
    TARGET_VEL  = 2'd1,
    TARGET_KP   = 2'd2,
    TARGET_KI   = 2'd3
  } target_t;

endpackage
`default_nettype wire

// ----- design/serial_command_frame_parser_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_parser_unit
// Parses received serial bytes into direction commands and brace-delimited
// parameter frames; one result per byte.
// Result valid is registered, rising in the cycle after the input transfer.
// Throughput: 1 byte per cycle while results are taken, set by the frame state
// update (saturating multiply-by-ten fold) feeding the output register.
// Reset: synchronous; clears frame state and the output valid.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_unit
  import scfp_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT,
  parameter int VALUE_BITS     = VALUE_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [7:0]  rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [3:0]  direction,
  output logic                    direction_set,
  output logic                    frame_end,
  output logic             [1:0]  update_target,
  output logic signed      [31:0] param_value,
  output logic                    pid_send_request,
  output logic                    flash_send_request
);

  localparam int POS_W = $clog2(FRAME_CAPACITY + 1);
  localparam int EXT_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(FRAME_CAPACITY);
  localparam logic [POS_W-1:0] POS_ID_IDX  = POS_W'(POS_ID);
  localparam logic [POS_W-1:0] POS_TAG_IDX = POS_W'(POS_TAG);

  logic                          in_frame;
  logic [POS_W-1:0]              frame_position;
  logic [7:0]                    frame_id_byte;
  logic [7:0]                    frame_tag_byte;
  logic signed [VALUE_BITS-1:0]  value_accumulator;

  logic                          in_frame_next;
  logic [POS_W-1:0]              frame_position_next;
  logic [7:0]                    frame_id_byte_next;
  logic [7:0]                    frame_tag_byte_next;
  logic signed [VALUE_BITS-1:0]  value_accumulator_next;
  logic signed [VALUE_BITS-1:0]  acc_folded;
  logic signed [EXT_W-1:0]       acc_ext;

  logic                          accept;
  logic                          collecting;
  logic [3:0]                    dir_d;
  logic                          dir_set_d;
  logic                          close_d;
  target_t                       target_d;
  logic signed [31:0]            value_d;
  logic                          pid_d;
  logic                          flash_d;

  scfp_fold #(
    .VALUE_BITS(VALUE_BITS)
  ) u_fold (
    .acc      (value_accumulator),
    .rx_byte  (rx_byte),
    .acc_next (acc_folded)
  );

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign acc_ext    = EXT_W'(value_accumulator);
  assign close_d    = (rx_byte == CH_CLOSE);
  assign collecting = (in_frame || (rx_byte == CH_OPEN)) && (frame_position < POS_LIMIT);

  always_comb begin
    dir_d     = 4'd0;
    dir_set_d = 1'b0;
    if (rx_byte >= CH_DIR_LO && rx_byte <= CH_DIR_HI) begin
      dir_d     = 4'(rx_byte - CH_DIR_BASE);
      dir_set_d = 1'b1;
    end else if (rx_byte < RAW_DIR_LIMIT) begin
      dir_d     = rx_byte[3:0];
      dir_set_d = 1'b1;
    end else if (rx_byte == CH_STOP) begin
      dir_set_d = 1'b1;
    end
  end

  always_comb begin
    target_d = TARGET_NONE;
    value_d  = 32'sd0;
    pid_d    = 1'b0;
    flash_d  = 1'b0;
    if (close_d) begin
      if (frame_tag_byte == CH_TAG_PID) begin
        pid_d = 1'b1;
      end else if (frame_tag_byte == CH_TAG_FLASH) begin
        flash_d = 1'b1;
      end else if (frame_id_byte != CH_ID_SKIP) begin
        case (frame_id_byte)
          CH_ID_VEL: target_d = TARGET_VEL;
          CH_ID_KP:  target_d = TARGET_KP;
          CH_ID_KI:  target_d = TARGET_KI;
          default:   target_d = TARGET_NONE;
        endcase
        if (target_d != TARGET_NONE) begin
          value_d = acc_ext[31:0];
        end
      end
    end
  end

  always_comb begin
    in_frame_next          = in_frame || (rx_byte == CH_OPEN);
    frame_position_next    = frame_position;
    frame_id_byte_next     = frame_id_byte;
    frame_tag_byte_next    = frame_tag_byte;
    value_accumulator_next = value_accumulator;
    if (close_d) begin
      in_frame_next          = 1'b0;
      frame_position_next    = '0;
      frame_id_byte_next     = 8'd0;
      frame_tag_byte_next    = 8'd0;
      value_accumulator_next = '0;
    end else if (collecting) begin
      if (frame_position == POS_ID_IDX) begin
        frame_id_byte_next = rx_byte;
      end
      if (frame_position == POS_TAG_IDX) begin
        frame_tag_byte_next = rx_byte;
      end
      if (frame_position >= POS_TAG_IDX) begin
        value_accumulator_next = acc_folded;
      end
      frame_position_next = frame_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      frame_position    <= '0;
      frame_id_byte     <= 8'd0;
      frame_tag_byte    <= 8'd0;
      value_accumulator <= '0;
    end else if (accept) begin
      in_frame          <= in_frame_next;
      frame_position    <= frame_position_next;
      frame_id_byte     <= frame_id_byte_next;
      frame_tag_byte    <= frame_tag_byte_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold result until its transfer completes
  always_ff @(posedge clk) begin
    if (accept) begin
      direction          <= dir_d;
      direction_set      <= dir_set_d;
      frame_end          <= close_d;
      update_target      <= target_d;
      param_value        <= value_d;
      pid_send_request   <= pid_d;
      flash_send_request <= flash_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/scfp_fold.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_fold
// Saturating decimal fold: acc * 10 + (byte - 48), clamped at the signed
// limits of the accumulator width.
// ----------------------------------------------------------------------------
module scfp_fold
  import scfp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic signed [VALUE_BITS-1:0] acc,
  input  wire logic        [7:0]            rx_byte,
  output logic signed      [VALUE_BITS-1:0] acc_next
);

  localparam int WIDE = VALUE_BITS + 5;
  localparam logic signed [VALUE_BITS-1:0] ACC_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] ACC_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] ACC_MAX_DIV10 = VALUE_BITS'(ACC_MAX / 10);
  localparam logic signed [VALUE_BITS-1:0] ACC_MIN_DIV10 = VALUE_BITS'(ACC_MIN / 10);

  logic signed [WIDE-1:0] acc_w;
  logic signed [WIDE-1:0] times_ten;
  logic signed [8:0]      digit;
  logic signed [WIDE-1:0] sum;

  assign acc_w     = WIDE'(acc);
  assign times_ten = (acc_w <<< 3) + (acc_w <<< 1);
  assign digit     = $signed({1'b0, rx_byte}) - DIGIT_BASE;
  assign sum       = times_ten + WIDE'(digit);

  always_comb begin
    if (acc > ACC_MAX_DIV10) begin
      acc_next = ACC_MAX;
    end else if (acc < ACC_MIN_DIV10) begin
      acc_next = ACC_MIN;
    end else if (sum > WIDE'(ACC_MAX)) begin
      acc_next = ACC_MAX;
    end else if (sum < WIDE'(ACC_MIN)) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = sum[VALUE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- verif/serial_command_frame_parser_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_unit_test
// Self-checking bench for the serial command frame parser. A short directed
// table covers the direction bytes, frame requests, the skip id, a nested
// opener and saturation. Random frames and noise follow, with random idling
// on both channels and one long result-side hold. Typed rows carry their own
// result, a parser model the rest; all are checked field by field in order.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_unit_test;
  import scfp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_FIVE = 8'h35;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_X = 8'h78;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [3:0] direction;
    logic direction_set;
    logic frame_end;
    target_t update_target;
    logic signed [31:0] param_value;
    logic pid_send_request;
    logic flash_send_request;
  } parser_result_t;

  localparam parser_result_t IDLE_RESULT = '0;

  typedef struct {
    logic [7:0] rx;
    int unsigned reps;
    bit typed;
    parser_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] direction;
  logic direction_set;
  logic frame_end;
  logic [1:0] update_target;
  logic signed [31:0] param_value;
  logic pid_send_request;
  logic flash_send_request;

  // stimulus store, one entry per byte
  logic [7:0] stim_bytes[$];
  bit stim_typed[$];
  parser_result_t stim_want[$];
  int unsigned cur_idx = 0;
  int unsigned directed_count;

  parser_result_t pending_results[$];

  // parser model state
  bit frame_open;
  int unsigned frame_pos;
  logic [7:0] frame_id;
  logic [7:0] frame_tag;
  longint frame_value;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned frames_closed = 0;
  int unsigned saturated_closes = 0;
  int unsigned overflow_bytes = 0;
  int unsigned typed_checks = 0;
  bit sender_burst = 1'b0;

  serial_command_frame_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .direction(direction),
    .direction_set(direction_set),
    .frame_end(frame_end),
    .update_target(update_target),
    .param_value(param_value),
    .pid_send_request(pid_send_request),
    .flash_send_request(flash_send_request)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic parser_result_t make_result(logic [3:0] dir, logic dir_set, logic fend,
                                                  target_t tgt, logic signed [31:0] val,
                                                  logic pid, logic flash);
    parser_result_t r;
    r.direction = dir;
    r.direction_set = dir_set;
    r.frame_end = fend;
    r.update_target = tgt;
    r.param_value = val;
    r.pid_send_request = pid;
    r.flash_send_request = flash;
    return r;
  endfunction

  function automatic longint fold_weight(longint acc, longint w);
    longint t;
    if (acc > VALUE_MAX / 10) return VALUE_MAX;
    if (acc < VALUE_MIN / 10) return VALUE_MIN;
    t = acc * 10;
    if (w > 0 && t > VALUE_MAX - w) return VALUE_MAX;
    if (w < 0 && t < VALUE_MIN - w) return VALUE_MIN;
    return t + w;
  endfunction

  function automatic void clear_frame();
    frame_open = 1'b0;
    frame_pos = 0;
    frame_id = 8'h00;
    frame_tag = 8'h00;
    frame_value = 0;
  endfunction

  function automatic parser_result_t parse_byte(logic [7:0] b);
    parser_result_t r;
    logic [7:0] code;
    r = IDLE_RESULT;
    if (b >= CH_DIR_LO && b <= CH_DIR_HI) begin
      code = b - CH_DIR_BASE;
      r.direction = code[3:0];
      r.direction_set = 1'b1;
    end else if (b < RAW_DIR_LIMIT) begin
      r.direction = b[3:0];
      r.direction_set = 1'b1;
    end else if (b == CH_STOP) begin
      r.direction_set = 1'b1;
    end
    if (b == CH_OPEN) frame_open = 1'b1;
    if (b == CH_CLOSE) begin
      r.frame_end = 1'b1;
      if (frame_tag == CH_TAG_PID) begin
        r.pid_send_request = 1'b1;
      end else if (frame_tag == CH_TAG_FLASH) begin
        r.flash_send_request = 1'b1;
      end else if (frame_id != CH_ID_SKIP) begin
        case (frame_id)
          CH_ID_VEL: r.update_target = TARGET_VEL;
          CH_ID_KP:  r.update_target = TARGET_KP;
          CH_ID_KI:  r.update_target = TARGET_KI;
          default:   r.update_target = TARGET_NONE;
        endcase
        if (r.update_target != TARGET_NONE) r.param_value = frame_value[31:0];
      end
      clear_frame();
    end else if (frame_open) begin
      if (frame_pos < FRAME_CAPACITY_DEFAULT) begin
        if (frame_pos == POS_ID) frame_id = b;
        if (frame_pos == POS_TAG) frame_tag = b;
        if (frame_pos >= POS_TAG)
          frame_value = fold_weight(frame_value, longint'(b) - longint'(DIGIT_BASE));
        frame_pos++;
      end else begin
        overflow_bytes++;
      end
    end
    return r;
  endfunction

  function automatic void add_byte(logic [7:0] b, bit typed = 1'b0,
                                   parser_result_t want = IDLE_RESULT);
    stim_bytes.push_back(b);
    stim_typed.push_back(typed);
    stim_want.push_back(want);
  endfunction

  task automatic build_directed();
    stim_row_t rows[$];
    rows = '{
      '{CH_CLOSE, 1, 1'b1, make_result(4'd0, 1'b0, 1'b1, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{8'h00, 1, 1'b1, make_result(4'd0, 1'b1, 1'b0, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{8'h09, 1, 1'b1, make_result(4'd9, 1'b1, 1'b0, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{8'h0A, 1, 1'b1, IDLE_RESULT},
      '{CH_DIR_LO, 1, 1'b1, make_result(4'd1, 1'b1, 1'b0, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{CH_DIR_HI, 1, 1'b1, make_result(4'd8, 1'b1, 1'b0, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{CH_STOP, 1, 1'b1, make_result(4'd0, 1'b1, 1'b0, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{8'hFF, 1, 1'b1, IDLE_RESULT},
      '{CH_OPEN, 1, 1'b0, IDLE_RESULT},
      '{CH_ID_KP, 1, 1'b0, IDLE_RESULT},
      '{CHAR_X, 1, 1'b0, IDLE_RESULT},
      '{CH_TAG_PID, 1, 1'b0, IDLE_RESULT},
      '{CH_CLOSE, 1, 1'b1, make_result(4'd0, 1'b0, 1'b1, TARGET_NONE, 0, 1'b1, 1'b0)},
      '{CH_OPEN, 1, 1'b0, IDLE_RESULT},
      '{CH_ID_KI, 1, 1'b0, IDLE_RESULT},
      '{CH_OPEN, 1, 1'b0, IDLE_RESULT},
      '{CH_TAG_FLASH, 1, 1'b0, IDLE_RESULT},
      '{CH_CLOSE, 1, 1'b1, make_result(4'd0, 1'b0, 1'b1, TARGET_NONE, 0, 1'b0, 1'b1)},
      '{CH_OPEN, 1, 1'b0, IDLE_RESULT},
      '{CH_ID_SKIP, 1, 1'b0, IDLE_RESULT},
      '{CHAR_X, 1, 1'b0, IDLE_RESULT},
      '{CHAR_FIVE, 1, 1'b0, IDLE_RESULT},
      '{CH_CLOSE, 1, 1'b1, make_result(4'd0, 1'b0, 1'b1, TARGET_NONE, 0, 1'b0, 1'b0)},
      '{CH_OPEN, 1, 1'b0, IDLE_RESULT},
      '{CH_ID_VEL, 1, 1'b0, IDLE_RESULT},
      '{CHAR_X, 1, 1'b0, IDLE_RESULT},
      '{8'hFF, 9, 1'b0, IDLE_RESULT},
      '{CH_CLOSE, 1, 1'b1,
        make_result(4'd0, 1'b0, 1'b1, TARGET_VEL, 32'sh7FFFFFFF, 1'b0, 1'b0)}
    };
    foreach (rows[i]) begin
      repeat (rows[i].reps) add_byte(rows[i].rx, rows[i].typed, rows[i].want);
    end
  endtask

  task automatic build_random(int unsigned count);
    int unsigned stop;
    int unsigned kind;
    int unsigned body_len;
    bit sat_run;
    logic [7:0] fill;
    stop = stim_bytes.size() + count;
    while (stim_bytes.size() < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_byte(CH_OPEN);
        case ($urandom_range(0, 5))
          0: add_byte(CH_ID_VEL);
          1: add_byte(CH_ID_KP);
          2: add_byte(CH_ID_KI);
          3: add_byte(CH_ID_SKIP);
          4: add_byte(8'($urandom_range(0, 255)));
          default: add_byte(CH_ID_VEL);
        endcase
        add_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 7))
          0: add_byte(CH_TAG_PID);
          1: add_byte(CH_TAG_FLASH);
          7: add_byte(8'($urandom_range(0, 255)));
          default: add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        endcase
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 10);
        sat_run = ($urandom_range(0, 7) == 0);
        fill = $urandom_range(0, 1) ? CHAR_NINE : 8'h00;
        repeat (body_len) begin
          if (sat_run) add_byte(fill);
          else if ($urandom_range(0, 9) != 0) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
          else add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) != 0) add_byte(CH_CLOSE);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0: add_byte(8'(CH_DIR_LO + $urandom_range(0, 7)));
          1: add_byte(8'($urandom_range(0, 9)));
          default: add_byte(CH_STOP);
        endcase
      end
    end
  endtask

  function automatic int unsigned pick_idle(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_result(input parser_result_t want, input parser_result_t got);
    if (got.direction !== want.direction) begin
      $error("direction: expected %0d, got %0d", want.direction, got.direction);
      mismatches++;
    end
    if (got.direction_set !== want.direction_set) begin
      $error("direction_set: expected %0d, got %0d", want.direction_set, got.direction_set);
      mismatches++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
      mismatches++;
    end
    if (got.update_target !== want.update_target) begin
      $error("update_target: expected %0d, got %0d", want.update_target, got.update_target);
      mismatches++;
    end
    if (got.param_value !== want.param_value) begin
      $error("param_value: expected %0d, got %0d", want.param_value, got.param_value);
      mismatches++;
    end
    if (got.pid_send_request !== want.pid_send_request) begin
      $error("pid_send_request: expected %0d, got %0d", want.pid_send_request,
             got.pid_send_request);
      mismatches++;
    end
    if (got.flash_send_request !== want.flash_send_request) begin
      $error("flash_send_request: expected %0d, got %0d", want.flash_send_request,
             got.flash_send_request);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    parser_result_t want;
    parser_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.direction = direction;
        got.direction_set = direction_set;
        got.frame_end = frame_end;
        got.update_target = target_t'(update_target);
        got.param_value = param_value;
        got.pid_send_request = pid_send_request;
        got.flash_send_request = flash_send_request;
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_result(want, got);
        end
      end
      if (in_valid && in_ready) begin
        want = parse_byte(rx_byte);
        if (stim_typed[cur_idx]) begin
          want = stim_want[cur_idx];
          typed_checks++;
        end
        if (want.frame_end) frames_closed++;
        if (want.update_target != TARGET_NONE &&
            (want.param_value == 32'sh7FFFFFFF || want.param_value == 32'sh80000000))
          saturated_closes++;
        pending_results.push_back(want);
      end
    end
  end

  // result side: random stalls, calm stretches, one long hold
  initial begin : drain_results
    int unsigned stall;
    int unsigned cycle;
    int unsigned next_switch;
    bit calm;
    bit long_hold_done;
    cycle = 0;
    next_switch = 0;
    calm = 1'b0;
    long_hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (cycle >= next_switch) begin
        calm = ($urandom_range(0, 3) == 0);
        next_switch = cycle + 128;
      end
      stall = pick_idle(calm);
      if (!long_hold_done && results_seen >= 300) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      cycle += stall + 1;
    end
  end

  initial begin : run_limit
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : feed_bytes
    int unsigned gap;
    clear_frame();
    build_directed();
    directed_count = stim_bytes.size();
    build_random(RANDOM_ITEMS);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int unsigned idx = 0; idx < stim_bytes.size(); idx++) begin
      if (idx % 100 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      gap = pick_idle(sender_burst);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= stim_bytes[idx];
      cur_idx <= idx;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    while (results_seen < stim_bytes.size()) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes (%0d directed, %0d with typed results), checked %0d results.",
             stim_bytes.size(), directed_count, typed_checks, results_seen);
    $display("Closed %0d frames, %0d saturated updates, %0d bytes past frame capacity.",
             frames_closed, saturated_closes, overflow_bytes);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/scfp_pkg.sv
design/scfp_fold.sv
design/serial_command_frame_parser_unit.sv
verif/serial_command_frame_parser_unit_test.sv
